FILE: rtl/core/ocp_pkg.sv
// Shared types, widths and constants of the orbit camera position block.
package ocp_pkg;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned ANG_W     = 9;
  localparam int unsigned DELTA_W   = 9;
  localparam int unsigned POS_W     = 21;
  localparam int unsigned STEP_W    = 9;
  localparam int unsigned RADIUS_W  = 12;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 12;

  localparam logic [ANG_W-1:0] FULL_TURN     = 9'd360;
  localparam logic [ANG_W-1:0] HALF_TURN     = 9'd180;
  localparam logic [ANG_W-1:0] QUARTER_TURN  = 9'd90;
  localparam logic [ANG_W-1:0] THREE_QUARTER = 9'd270;
  localparam int              ELEV_LOW      = -80;
  localparam int              ELEV_HIGH     = 80;

  typedef enum logic [CMD_W-1:0] {
    CMD_UP     = 3'd0,
    CMD_DOWN   = 3'd1,
    CMD_LEFT   = 3'd2,
    CMD_RIGHT  = 3'd3,
    CMD_SET_XY = 3'd4,
    CMD_QUERY  = 3'd5
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_DEGREES = 1'd0,
    REG_RADIUS       = 1'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_Y = 2'd0,
    OP_P = 2'd1,
    OP_X = 2'd2,
    OP_Z = 2'd3
  } mul_op_e;

  typedef struct packed {
    logic    accept;
    logic    look;
    logic    mul_en;
    mul_op_e mul_op;
    logic    out_load;
  } dp_cmd_t;

  localparam logic [15:0] SINE_Q15 [91] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

endpackage

FILE: rtl/core/ocp_in_if.sv
// Command channel: valid/ready with the command payload.
interface ocp_in_if;
  import ocp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [DELTA_W-1:0] delta_elevation;
  logic signed [DELTA_W-1:0] delta_azimuth;

  modport source (output valid, cmd, delta_elevation, delta_azimuth, input ready);
  modport sink   (input valid, cmd, delta_elevation, delta_azimuth, output ready);
endinterface

FILE: rtl/core/ocp_out_if.sv
// Result channel: valid/ready with the orbit point and current angles.
interface ocp_out_if;
  import ocp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [ANG_W-1:0]        elevation_now;
  logic [ANG_W-1:0]        azimuth_now;

  modport source (output valid, pos_x, pos_y, pos_z, elevation_now, azimuth_now,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, elevation_now, azimuth_now,
                  output ready);
endinterface

FILE: rtl/core/ocp_ctrl.sv
// Sequencer: steps one item through table lookup and four shared multiplies.
module ocp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ocp_pkg::dp_cmd_t cmd_o
);
  import ocp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MUL_Y,
    ST_MUL_P,
    ST_MUL_X,
    ST_MUL_Z,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    cmd_o          = '0;
    cmd_o.mul_op   = OP_Y;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = OP_Y;
        state_d      = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = OP_P;
        state_d      = ST_MUL_X;
      end
      ST_MUL_X: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = OP_X;
        state_d      = ST_MUL_Z;
      end
      ST_MUL_Z: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = OP_Z;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/core/ocp_dpath.sv
// Datapath: angle registers, sine table, shared multiplier, rounding, result register.
module ocp_dpath #(
  parameter int unsigned RADIUS_BITS    = 12,
  parameter int unsigned SINE_FRAC_BITS = 15,
  parameter int unsigned OUT_FRAC_BITS  = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  ocp_pkg::dp_cmd_t                        cmd_i,
  input  logic                                    cfg_we_i,
  input  logic [ocp_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [ocp_pkg::CFG_W-1:0]               cfg_data_i,
  input  logic [ocp_pkg::CMD_W-1:0]               in_cmd_i,
  input  logic signed [ocp_pkg::DELTA_W-1:0]      in_delta_el_i,
  input  logic signed [ocp_pkg::DELTA_W-1:0]      in_delta_az_i,
  output logic signed [ocp_pkg::POS_W-1:0]        pos_x_o,
  output logic signed [ocp_pkg::POS_W-1:0]        pos_y_o,
  output logic signed [ocp_pkg::POS_W-1:0]        pos_z_o,
  output logic [ocp_pkg::ANG_W-1:0]               elevation_now_o,
  output logic [ocp_pkg::ANG_W-1:0]               azimuth_now_o
);
  import ocp_pkg::*;

  localparam int unsigned RW      = (RADIUS_BITS < RADIUS_W) ? RADIUS_BITS : RADIUS_W;
  localparam int unsigned SW      = SINE_FRAC_BITS + 1;
  localparam int unsigned PW      = RW + SW;
  localparam int unsigned MW      = PW + SW;
  localparam int unsigned EW      = MW + 16;
  localparam int unsigned TW      = 18;
  localparam int unsigned UP      = (SINE_FRAC_BITS >= 15) ? SINE_FRAC_BITS - 15 : 0;
  localparam int unsigned DN      = (SINE_FRAC_BITS >= 15) ? 0 : 15 - SINE_FRAC_BITS;
  localparam int unsigned SHY     = (SINE_FRAC_BITS >= OUT_FRAC_BITS) ?
                                    SINE_FRAC_BITS - OUT_FRAC_BITS : 0;
  localparam int unsigned LSY     = (SINE_FRAC_BITS >= OUT_FRAC_BITS) ?
                                    0 : OUT_FRAC_BITS - SINE_FRAC_BITS;
  localparam int unsigned SHXZ    = 2 * SINE_FRAC_BITS - OUT_FRAC_BITS;
  localparam logic [TW-1:0] HALF_DN   = TW'((64'd1 << DN) >> 1);
  localparam logic [EW-1:0] HALF_Y    = EW'((64'd1 << SHY) >> 1);
  localparam logic [EW-1:0] HALF_XZ   = EW'((64'd1 << SHXZ) >> 1);

  function automatic logic [ANG_W-1:0] add_wrap(input logic [ANG_W-1:0] a,
                                                input logic [ANG_W-1:0] b);
    logic [ANG_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, FULL_TURN}) ? ANG_W'(s - {1'b0, FULL_TURN}) : s[ANG_W-1:0];
  endfunction

  function automatic logic [ANG_W-1:0] sub_wrap(input logic [ANG_W-1:0] a,
                                                input logic [ANG_W-1:0] b);
    logic [ANG_W:0] s;
    s = {1'b0, a} + {1'b0, FULL_TURN} - {1'b0, b};
    return (s >= {1'b0, FULL_TURN}) ? ANG_W'(s - {1'b0, FULL_TURN}) : s[ANG_W-1:0];
  endfunction

  // {negative, magnitude} of the sine of an angle in 0..359
  function automatic logic [SW:0] sin_lookup(input logic [ANG_W-1:0] a);
    logic [ANG_W-1:0] f;
    logic [TW-1:0]    t;
    logic [TW-1:0]    sc;
    if (a <= QUARTER_TURN)       f = a;
    else if (a <= HALF_TURN)     f = HALF_TURN - a;
    else if (a <= THREE_QUARTER) f = a - HALF_TURN;
    else                         f = FULL_TURN - a;
    t  = TW'(SINE_Q15[f[6:0]]);
    sc = ((t + HALF_DN) >> DN) << UP;
    return {(a > HALF_TURN), sc[SW-1:0]};
  endfunction

  logic [STEP_W-1:0]   step_q;
  logic [RADIUS_W-1:0] radius_q;
  logic [ANG_W-1:0]    el_q, el_d, az_q, az_d;
  logic [ANG_W-1:0]    st;
  logic [SW:0]         l_s_el, l_c_el, l_s_az, l_c_az;
  logic [SW-1:0]       s_el_q, c_el_q, s_az_q, c_az_q;
  logic                neg_x_q, neg_y_q, neg_z_q;
  logic [PW-1:0]       proj_q, mul_a;
  logic [SW-1:0]       mul_b;
  logic [MW-1:0]       prod_q;
  logic [EW-1:0]       y_ext, xz_ext;
  logic [POS_W-1:0]    y_rnd, xz_rnd, x_q, y_q;

  logic signed [ANG_W:0]   se;
  logic signed [ANG_W+1:0] ne, sa;

  assign st = (step_q >= FULL_TURN) ? step_q - FULL_TURN : step_q;
  assign se = (el_q >= HALF_TURN) ? $signed({1'b0, el_q}) - $signed({1'b0, FULL_TURN})
                                  : $signed({1'b0, el_q});
  assign ne = (ANG_W+2)'(se) + (ANG_W+2)'(in_delta_el_i);
  assign sa = $signed({2'b00, az_q}) + (ANG_W+2)'(in_delta_az_i);

  always_comb begin
    el_d = el_q;
    az_d = az_q;
    unique case (in_cmd_i)
      CMD_UP:    el_d = add_wrap(el_q, st);
      CMD_DOWN:  el_d = sub_wrap(el_q, st);
      CMD_LEFT:  az_d = sub_wrap(az_q, st);
      CMD_RIGHT: az_d = add_wrap(az_q, st);
      CMD_SET_XY: begin
        if (ne > (ANG_W+2)'(ELEV_LOW) && ne < (ANG_W+2)'(ELEV_HIGH)) begin
          el_d = (ne < 0) ? ANG_W'(ne + $signed({2'b00, FULL_TURN})) : ANG_W'(ne);
        end
        if (sa < 0) begin
          az_d = ANG_W'(sa + $signed({2'b00, FULL_TURN}));
        end else if (sa >= $signed({2'b00, FULL_TURN})) begin
          az_d = ANG_W'(sa - $signed({2'b00, FULL_TURN}));
        end else begin
          az_d = ANG_W'(sa);
        end
      end
      default: ;
    endcase
  end

  assign l_s_el = sin_lookup(el_q);
  assign l_c_el = sin_lookup(add_wrap(el_q, QUARTER_TURN));
  assign l_s_az = sin_lookup(az_q);
  assign l_c_az = sin_lookup(add_wrap(az_q, QUARTER_TURN));

  always_comb begin
    unique case (cmd_i.mul_op)
      OP_Y: begin mul_a = PW'(radius_q[RW-1:0]); mul_b = s_el_q; end
      OP_P: begin mul_a = PW'(radius_q[RW-1:0]); mul_b = c_el_q; end
      OP_X: begin mul_a = prod_q[PW-1:0];        mul_b = c_az_q; end
      OP_Z: begin mul_a = proj_q;                mul_b = s_az_q; end
      default: begin mul_a = '0;                 mul_b = '0;     end
    endcase
  end

  assign y_ext  = ((EW'(prod_q) + HALF_Y) >> SHY) << LSY;
  assign xz_ext = (EW'(prod_q) + HALF_XZ) >> SHXZ;
  assign y_rnd  = y_ext[POS_W-1:0];
  assign xz_rnd = xz_ext[POS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= STEP_W'(1);
      radius_q <= RADIUS_W'(5);
      el_q     <= '0;
      az_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_STEP_DEGREES: step_q   <= cfg_data_i[STEP_W-1:0];
          REG_RADIUS:       radius_q <= cfg_data_i[RADIUS_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        el_q <= el_d;
        az_q <= az_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      s_el_q  <= l_s_el[SW-1:0];
      c_el_q  <= l_c_el[SW-1:0];
      s_az_q  <= l_s_az[SW-1:0];
      c_az_q  <= l_c_az[SW-1:0];
      neg_y_q <= l_s_el[SW];
      neg_x_q <= l_c_el[SW] ^ l_c_az[SW];
      neg_z_q <= ~(l_c_el[SW] ^ l_s_az[SW]);
    end
    if (cmd_i.mul_en) begin
      prod_q <= MW'(mul_a) * MW'(mul_b);
      unique case (cmd_i.mul_op)
        OP_P:    y_q    <= neg_y_q ? POS_W'(-y_rnd) : y_rnd;
        OP_X:    proj_q <= prod_q[PW-1:0];
        OP_Z:    x_q    <= neg_x_q ? POS_W'(-xz_rnd) : xz_rnd;
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      pos_x_o         <= x_q;
      pos_y_o         <= y_q;
      pos_z_o         <= neg_z_q ? POS_W'(-xz_rnd) : xz_rnd;
      elevation_now_o <= el_q;
      azimuth_now_o   <= az_q;
    end
  end

endmodule

FILE: rtl/core/orbit_camera_position.sv
// Orbit camera position: top level joining the sequencer and the datapath.
// A command steps through a lookup state, four multiply states that share the
// single multiplier in turn, and a finish state that loads the result once the
// output register is free. No new command is taken until the finish state is left.
// A finished result waits in the output register while the next command is taken.
// Reset: elevation and azimuth 0, step_degrees 1, radius 5, no result pending.
module orbit_camera_position #(
  parameter int unsigned RADIUS_BITS    = 12,
  parameter int unsigned SINE_FRAC_BITS = 15,
  parameter int unsigned OUT_FRAC_BITS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ocp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ocp_pkg::CFG_W-1:0]     cfg_data_i,
  ocp_in_if.sink                        in_i,
  ocp_out_if.source                     out_o
);
  import ocp_pkg::*;

  dp_cmd_t dp_cmd;

  ocp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (dp_cmd)
  );

  ocp_dpath #(
    .RADIUS_BITS    (RADIUS_BITS),
    .SINE_FRAC_BITS (SINE_FRAC_BITS),
    .OUT_FRAC_BITS  (OUT_FRAC_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_cmd_i        (in_i.cmd),
    .in_delta_el_i   (in_i.delta_elevation),
    .in_delta_az_i   (in_i.delta_azimuth),
    .pos_x_o         (out_o.pos_x),
    .pos_y_o         (out_o.pos_y),
    .pos_z_o         (out_o.pos_z),
    .elevation_now_o (out_o.elevation_now),
    .azimuth_now_o   (out_o.azimuth_now)
  );

endmodule

FILE: verif/orbit_camera_position_tb.sv
// Self-checking testbench for orbit_camera_position: commands, settings and predicted orbit points.
`timescale 1ns / 100ps
module orbit_camera_position_tb;
  import ocp_pkg::*;

  localparam int unsigned RADIUS_BITS     = 12;
  localparam int unsigned SINE_FRAC_BITS  = 15;
  localparam int unsigned OUT_FRAC_BITS   = 8;
  localparam int unsigned TABLE_FRAC_BITS = 15;
  localparam int unsigned Y_SHIFT         = SINE_FRAC_BITS - OUT_FRAC_BITS;
  localparam int unsigned XZ_SHIFT        = 2 * SINE_FRAC_BITS - OUT_FRAC_BITS;
  localparam int unsigned TURN            = FULL_TURN;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  localparam int unsigned IDLE_PERCENT = 26;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_ITEMS   = 40;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned PHASES       = 5;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    logic [ANG_W-1:0] el;
    logic [ANG_W-1:0] az;
  } orbit_point_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  ocp_in_if  cmd_if ();
  ocp_out_if point_if ();

  orbit_camera_position #(
    .RADIUS_BITS   (RADIUS_BITS),
    .SINE_FRAC_BITS(SINE_FRAC_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_i (cmd_if),
    .out_o(point_if)
  );

  int unsigned  step_q   = 1;
  int unsigned  radius_q = 5;
  int unsigned  elev_q   = 0;
  int unsigned  azim_q   = 0;
  orbit_point_t orbit_expected[$];

  bit          steady        = 1'b0;
  bit          hold_request  = 1'b0;
  int unsigned sent_count    = 0;
  int unsigned checked_count = 0;
  int unsigned error_count   = 0;
  int unsigned refusal_count = 0;
  int unsigned config_count  = 0;
  int unsigned cycle_count   = 0;

  cmd_e moves [4] = '{CMD_UP, CMD_DOWN, CMD_LEFT, CMD_RIGHT};

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("orbit_camera_position_tb: FAIL");
      $finish;
    end
  end

  function automatic longint unsigned sine_magnitude(int unsigned deg, output bit neg);
    int unsigned a;
    int unsigned idx;
    a   = deg % TURN;
    neg = a > TURN / 2;
    if (a <= TURN / 4) idx = a;
    else if (a <= TURN / 2) idx = TURN / 2 - a;
    else if (a <= 3 * TURN / 4) idx = a - TURN / 2;
    else idx = TURN - a;
    return longint'(SINE_Q15[idx]) << (SINE_FRAC_BITS - TABLE_FRAC_BITS);
  endfunction

  function automatic int signed_elevation(int unsigned el);
    return (el >= TURN / 2) ? int'(el) - int'(TURN) : int'(el);
  endfunction

  function automatic orbit_point_t advance_orbit(logic [CMD_W-1:0] cmd,
                                                 logic signed [DELTA_W-1:0] d_el,
                                                 logic signed [DELTA_W-1:0] d_az);
    orbit_point_t      pt;
    int unsigned       st;
    int                new_el;
    longint unsigned   r, s_el, c_el, s_az, c_az, proj, mag_x, mag_y, mag_z;
    bit                ns_el, nc_el, ns_az, nc_az;
    st = step_q % TURN;
    r  = radius_q & ((1 << RADIUS_BITS) - 1);
    case (cmd)
      CMD_UP:    elev_q = (elev_q + st) % TURN;
      CMD_DOWN:  elev_q = (elev_q + TURN - st) % TURN;
      CMD_LEFT:  azim_q = (azim_q + TURN - st) % TURN;
      CMD_RIGHT: azim_q = (azim_q + st) % TURN;
      CMD_SET_XY: begin
        new_el = signed_elevation(elev_q) + int'(d_el);
        if (new_el > ELEV_LOW && new_el < ELEV_HIGH) elev_q = (new_el + int'(TURN)) % int'(TURN);
        else refusal_count++;
        azim_q = (int'(azim_q) + int'(d_az) + 2 * int'(TURN)) % int'(TURN);
      end
      default: ;
    endcase
    s_el  = sine_magnitude(elev_q, ns_el);
    c_el  = sine_magnitude(elev_q + QUARTER_TURN, nc_el);
    s_az  = sine_magnitude(azim_q, ns_az);
    c_az  = sine_magnitude(azim_q + QUARTER_TURN, nc_az);
    mag_y = (r * s_el + (64'd1 << (Y_SHIFT - 1))) >> Y_SHIFT;
    proj  = r * c_el;
    mag_x = (proj * c_az + (64'd1 << (XZ_SHIFT - 1))) >> XZ_SHIFT;
    mag_z = (proj * s_az + (64'd1 << (XZ_SHIFT - 1))) >> XZ_SHIFT;
    pt.x  = POS_W'((nc_el != nc_az) ? 64'd0 - mag_x : mag_x);
    pt.y  = POS_W'(ns_el ? 64'd0 - mag_y : mag_y);
    pt.z  = POS_W'((nc_el == ns_az) ? 64'd0 - mag_z : mag_z);
    pt.el = ANG_W'(elev_q);
    pt.az = ANG_W'(azim_q);
    return pt;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : transfer_monitor
    orbit_point_t want;
    if (rst_ni) begin
      if (point_if.valid && point_if.ready) begin
        if (orbit_expected.size() == 0) begin
          $error("orbit point transfer with no command outstanding");
          error_count++;
        end else begin
          want = orbit_expected.pop_front();
          check_field("pos_x", $signed(want.x), point_if.pos_x);
          check_field("pos_y", $signed(want.y), point_if.pos_y);
          check_field("pos_z", $signed(want.z), point_if.pos_z);
          check_field("elevation_now", want.el, point_if.elevation_now);
          check_field("azimuth_now", want.az, point_if.azimuth_now);
          checked_count++;
        end
      end
      if (cmd_if.valid && cmd_if.ready)
        orbit_expected.push_back(advance_orbit(cmd_if.cmd, cmd_if.delta_elevation,
                                               cmd_if.delta_azimuth));
    end
  end

  initial begin
    point_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        point_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        point_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic signed [DELTA_W-1:0] d_el,
                          logic signed [DELTA_W-1:0] d_az);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid           <= 1'b1;
    cmd_if.cmd             <= cmd;
    cmd_if.delta_elevation <= d_el;
    cmd_if.delta_azimuth   <= d_az;
    do @(posedge clk_i); while (!cmd_if.ready);
    sent_count++;
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    while (checked_count < sent_count) @(posedge clk_i);
  endtask

  task automatic set_orbit_config(logic [CFG_W-1:0] step_data, logic [CFG_W-1:0] radius_data);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_STEP_DEGREES;
    cfg_data_i <= step_data;
    @(posedge clk_i);
    step_q = step_data[STEP_W-1:0];
    cfg_idx_i  <= REG_RADIUS;
    cfg_data_i <= radius_data;
    @(posedge clk_i);
    radius_q = radius_data[RADIUS_W-1:0];
    cfg_we_i <= 1'b0;
    config_count++;
  endtask

  task automatic send_random_cmd();
    int unsigned pick;
    int          aim;
    pick = $urandom_range(99);
    if (pick < 35) begin
      // aim just past the elevation limits now and then
      aim = int'($urandom_range(170)) - 85;
      send_cmd(CMD_SET_XY, DELTA_W'(aim - signed_elevation(elev_q)), DELTA_W'($urandom));
    end else if (pick < 47) begin
      send_cmd(CMD_SET_XY, DELTA_W'($urandom), DELTA_W'($urandom));
    end else if (pick < 85) begin
      send_cmd(moves[$urandom_range(3)], DELTA_W'($urandom), DELTA_W'($urandom));
    end else if (pick < 95) begin
      send_cmd(CMD_QUERY, DELTA_W'($urandom), DELTA_W'($urandom));
    end else begin
      send_cmd($urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B, DELTA_W'($urandom),
               DELTA_W'($urandom));
    end
  endtask

  task automatic test_reset_state();
    send_cmd(CMD_QUERY, '0, '0);
    send_cmd(CMD_SPARE_A, 9'sd100, -9'sd100);
    send_cmd(CMD_SPARE_B, 9'sd255, 9'h100);
  endtask

  task automatic test_single_steps();
    send_cmd(CMD_DOWN, '0, '0);
    send_cmd(CMD_UP, '0, '0);
    send_cmd(CMD_UP, '0, '0);
    send_cmd(CMD_LEFT, '0, '0);
    send_cmd(CMD_RIGHT, '0, '0);
    send_cmd(CMD_RIGHT, '0, '0);
  endtask

  task automatic test_elevation_limit();
    set_orbit_config(12'd1, 12'd4095);
    send_cmd(CMD_SET_XY, 9'sd78, 9'sd180);
    send_cmd(CMD_SET_XY, 9'sd1, -9'sd180);
    send_cmd(CMD_SET_XY, -9'sd158, 9'sd0);
    send_cmd(CMD_SET_XY, -9'sd1, 9'sd255);
    send_cmd(CMD_SET_XY, 9'sd255, 9'h100);
    send_cmd(CMD_SET_XY, 9'h100, 9'sd1);
    send_cmd(CMD_SET_XY, 9'sd79, -9'sd1);
    send_cmd(CMD_SET_XY, -9'sd79, 9'sd90);
  endtask

  task automatic test_large_step();
    set_orbit_config(12'd360, 12'd0);
    send_cmd(CMD_UP, '0, '0);
    send_cmd(CMD_LEFT, '0, '0);
    set_orbit_config(12'd511, 12'd4095);
    send_cmd(CMD_UP, '0, '0);
    send_cmd(CMD_RIGHT, '0, '0);
    send_cmd(CMD_DOWN, '0, '0);
    set_orbit_config(12'd359, 12'd4095);
    send_cmd(CMD_LEFT, '0, '0);
    send_cmd(CMD_UP, '0, '0);
    send_cmd(CMD_SET_XY, 9'sd0, 9'sd0);
  endtask

  task automatic test_backpressure();
    set_orbit_config(12'd7, 12'd2048);
    hold_request = 1'b1;
    repeat (HOLD_ITEMS) send_random_cmd();
    wait_drained();
    repeat (HOLD_ITEMS) send_random_cmd();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_orbit_config(CFG_W'($urandom_range(1, 20)), CFG_W'($urandom_range(4095)));
        1: set_orbit_config(CFG_W'($urandom), CFG_W'($urandom));
        2: set_orbit_config(12'd90, 12'd4095);
        3: set_orbit_config(12'd1, CFG_W'($urandom_range(1, 4095)));
        default: set_orbit_config(12'd359, 12'd1);
      endcase
      // no idling on either side for one whole phase
      steady = (phase == 2);
      repeat (PHASE_ITEMS) send_random_cmd();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= REG_STEP_DEGREES;
    cfg_data_i             <= '0;
    cmd_if.valid           <= 1'b0;
    cmd_if.cmd             <= CMD_QUERY;
    cmd_if.delta_elevation <= '0;
    cmd_if.delta_azimuth   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_single_steps();
    test_elevation_limit();
    test_large_step();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d commands of every kind, spare codes included, under %0d settings.",
             sent_count, config_count);
    $display("Elevation refused %0d times; one %0d-cycle result hold-off, one idle-free phase.",
             refusal_count, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("orbit_camera_position_tb: PASS");
    end else begin
      $display("orbit_camera_position_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ocp_pkg.sv
rtl/core/ocp_in_if.sv
rtl/core/ocp_out_if.sv
rtl/core/ocp_ctrl.sv
rtl/core/ocp_dpath.sv
rtl/core/orbit_camera_position.sv
verif/orbit_camera_position_tb.sv
